// File: sv/epr_pkg.sv
// ----------------------------------------------------------------------------
// epr_pkg
// Shared widths, register indexes, payload types and the sine table generator
// for the euler point rotator.
// ----------------------------------------------------------------------------
package epr_pkg;

    // default angle resolution, 2^ANGLE_BITS steps per turn
    localparam int ANGLE_BITS_DEF = 10;

    // coordinate and trig widths
    localparam int COORD_W     = 32;
    localparam int TRIG_W      = 17;
    localparam int PROD_W      = COORD_W + TRIG_W;
    localparam int SUM_W       = PROD_W + 1;
    localparam int ROUND_SHIFT = 15;
    localparam int CFG_ADDR_W  = 2;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_ANGLE_XY = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ANGLE_YZ = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ANGLE_XZ = 2'd2;

    // one point in flight: the rotated pair (u, v), the untouched axis w
    typedef struct packed {
        logic signed [COORD_W-1:0] u;
        logic signed [COORD_W-1:0] v;
        logic signed [COORD_W-1:0] w;
        logic                      clamp;
    } rot_t;

    // round(32768 * sin(k * step)), evaluated at elaboration
    function automatic logic [TRIG_W-2:0] sine_q15(input int k, input real step);
        real t;
        t = step * real'(k);
        return (TRIG_W-1)'($rtoi($floor(32768.0 * $sin(t) + 0.5)));
    endfunction

endpackage

// File: sv/epr_trig.sv
// ----------------------------------------------------------------------------
// epr_trig
// Quarter-wave sine table lookup; registers cosine and sine of one angle.
// ----------------------------------------------------------------------------
module epr_trig #(
    parameter int ANGLE_BITS = epr_pkg::ANGLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [ANGLE_BITS-1:0]             angle,
    output logic signed [epr_pkg::TRIG_W-1:0] cos_reg,
    output logic signed [epr_pkg::TRIG_W-1:0] sin_reg
);

    localparam int QUARTER = 1 << (ANGLE_BITS - 2);
    localparam int IDX_W   = ANGLE_BITS - 1;
    localparam int MAG_W   = epr_pkg::TRIG_W - 1;
    // table step in radians
    localparam real STEP   = 1.5707963267948966 / real'(QUARTER);

    logic [MAG_W-1:0] rom [0:QUARTER];
    logic [ANGLE_BITS-1:0] ang [0:1];
    logic signed [epr_pkg::TRIG_W-1:0] val [0:1];

    // constant quarter-wave table
    genvar k;
    generate
        for (k = 0; k <= QUARTER; k++)
        begin : g_rom
            assign rom[k] = epr_pkg::sine_q15(k, STEP);
        end
    endgenerate

    // sine at angle, cosine as sine a quarter turn ahead
    assign ang[0] = angle;
    assign ang[1] = angle + ANGLE_BITS'(QUARTER);

    // quadrant fold and sign
    always_comb
    begin
        logic [1:0]             quad;
        logic [IDX_W-1:0]       idx;
        logic [MAG_W-1:0]       mag;
        logic signed [epr_pkg::TRIG_W-1:0] smag;
        for (int i = 0; i < 2; i++)
        begin
            quad = ang[i][ANGLE_BITS-1 -: 2];
            if (quad[0])
                idx = IDX_W'(QUARTER) - {1'b0, ang[i][ANGLE_BITS-3:0]};
            else
                idx = {1'b0, ang[i][ANGLE_BITS-3:0]};
            mag  = rom[idx];
            smag = $signed({1'b0, mag});
            val[i] = quad[1] ? -smag : smag;
        end
    end

    // registered trig values, reset to angle zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sin_reg <= '0;
            cos_reg <= epr_pkg::TRIG_W'(32768);
        end
        else
        begin
            sin_reg <= val[0];
            cos_reg <= val[1];
        end
    end

endmodule

// File: sv/epr_rotate.sv
// ----------------------------------------------------------------------------
// epr_rotate
// Two-stage plane rotation: products in the first stage, rounded and
// saturated sums in the second. Each stage holds only while full and the next one cannot take its point.
// ----------------------------------------------------------------------------
module epr_rotate (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic signed [epr_pkg::TRIG_W-1:0] cos_val,
    input  logic signed [epr_pkg::TRIG_W-1:0] sin_val,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  epr_pkg::rot_t                     in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output epr_pkg::rot_t                     out_data
);

    localparam int SH_W = epr_pkg::SUM_W - epr_pkg::ROUND_SHIFT;
    localparam logic signed [epr_pkg::SUM_W-1:0] ROUND_ADD =
        epr_pkg::SUM_W'(1) <<< (epr_pkg::ROUND_SHIFT - 1);

    typedef struct packed {
        logic signed [epr_pkg::COORD_W-1:0] value;
        logic                               clamp;
    } sat_t;

    // product stage
    logic                               va_reg;
    logic signed [epr_pkg::PROD_W-1:0]  uc_reg, vs_reg, us_reg, vc_reg;
    logic signed [epr_pkg::COORD_W-1:0] wa_reg;
    logic                               ca_reg;

    // sum stage
    logic          vb_reg;
    epr_pkg::rot_t db_reg, db_next;

    logic rdy_a, rdy_b;

    // round, then clamp to the coordinate range
    function automatic sat_t round_sat(input logic signed [epr_pkg::SUM_W-1:0] sum);
        logic signed [epr_pkg::SUM_W-1:0] rnd;
        logic [SH_W-1:0]                  sh;
        logic [SH_W-epr_pkg::COORD_W:0]   hi;
        sat_t                             res;
        rnd = sum + ROUND_ADD;
        sh  = rnd[epr_pkg::SUM_W-1:epr_pkg::ROUND_SHIFT];
        hi  = sh[SH_W-1:epr_pkg::COORD_W-1];
        if ((&hi) || !(|hi))
        begin
            res.value = $signed(sh[epr_pkg::COORD_W-1:0]);
            res.clamp = 1'b0;
        end
        else
        begin
            res.value = sh[SH_W-1] ? {1'b1, {(epr_pkg::COORD_W-1){1'b0}}}
                                   : {1'b0, {(epr_pkg::COORD_W-1){1'b1}}};
            res.clamp = 1'b1;
        end
        return res;
    endfunction

    // stage readiness
    assign rdy_b    = !vb_reg || out_ready;
    assign rdy_a    = !va_reg || rdy_b;
    assign in_ready = rdy_a;

    // product stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (rdy_a)
            va_reg <= in_valid;
    end

    // product stage data
    always_ff @(posedge clk)
    begin
        if (rdy_a && in_valid)
        begin
            uc_reg <= epr_pkg::PROD_W'(in_data.u * cos_val);
            vs_reg <= epr_pkg::PROD_W'(in_data.v * sin_val);
            us_reg <= epr_pkg::PROD_W'(in_data.u * sin_val);
            vc_reg <= epr_pkg::PROD_W'(in_data.v * cos_val);
            wa_reg <= in_data.w;
            ca_reg <= in_data.clamp;
        end
    end

    // sums, rounding and saturation
    always_comb
    begin
        logic signed [epr_pkg::SUM_W-1:0] sum_u, sum_v;
        sat_t                             ru, rv;
        sum_u = $signed({uc_reg[epr_pkg::PROD_W-1], uc_reg})
              - $signed({vs_reg[epr_pkg::PROD_W-1], vs_reg});
        sum_v = $signed({us_reg[epr_pkg::PROD_W-1], us_reg})
              + $signed({vc_reg[epr_pkg::PROD_W-1], vc_reg});
        ru = round_sat(sum_u);
        rv = round_sat(sum_v);
        db_next.u     = ru.value;
        db_next.v     = rv.value;
        db_next.w     = wa_reg;
        db_next.clamp = ca_reg | ru.clamp | rv.clamp;
    end

    // sum stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else if (rdy_b)
            vb_reg <= va_reg;
    end

    // sum stage data
    always_ff @(posedge clk)
    begin
        if (rdy_b && va_reg)
            db_reg <= db_next;
    end

    assign out_valid = vb_reg;
    assign out_data  = db_reg;

endmodule

// File: sv/euler_point_rotator.sv
// Throughput: one point per cycle while the output is not stalled; input,
// three rotation units of two stages each (multiply, then round and
// saturate), each stage holds only when full.
// Angle writes pass through the angle registers into the trig registers.
// Reset clears all stage valid bits and sets the three angles to zero.
// ----------------------------------------------------------------------------
// euler_point_rotator
// Rotates Q16.16 points in the xy, yz and xz planes by configured angles.
// ----------------------------------------------------------------------------
module euler_point_rotator #(
    parameter int ANGLE_BITS = epr_pkg::ANGLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [epr_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [ANGLE_BITS-1:0]                 cfg_data,
    // points in
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [epr_pkg::COORD_W-1:0]    in_x,
    input  logic signed [epr_pkg::COORD_W-1:0]    in_y,
    input  logic signed [epr_pkg::COORD_W-1:0]    in_z,
    // points out
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [epr_pkg::COORD_W-1:0]    out_x,
    output logic signed [epr_pkg::COORD_W-1:0]    out_y,
    output logic signed [epr_pkg::COORD_W-1:0]    out_z,
    output logic                                  clamped
);

    logic [ANGLE_BITS-1:0] angle_xy_reg, angle_yz_reg, angle_xz_reg;

    logic signed [epr_pkg::TRIG_W-1:0] cos_xy, sin_xy, cos_yz, sin_yz, cos_xz, sin_xz;

    logic          v0_reg, rdy0;
    epr_pkg::rot_t d0_reg;

    logic          v1, r1, v2, r2, v3, r1_in, r2_in;
    epr_pkg::rot_t d1, d2, d3, d2_in, d3_in;

    // configuration writes, always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_xy_reg <= '0;
            angle_yz_reg <= '0;
            angle_xz_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_addr)
                epr_pkg::REG_ANGLE_XY: angle_xy_reg <= cfg_data;
                epr_pkg::REG_ANGLE_YZ: angle_yz_reg <= cfg_data;
                epr_pkg::REG_ANGLE_XZ: angle_xz_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // trig lookups
    epr_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_xy (
        .clk(clk), .rst_n(rst_n), .angle(angle_xy_reg), .cos_reg(cos_xy), .sin_reg(sin_xy)
    );
    epr_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_yz (
        .clk(clk), .rst_n(rst_n), .angle(angle_yz_reg), .cos_reg(cos_yz), .sin_reg(sin_yz)
    );
    epr_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_xz (
        .clk(clk), .rst_n(rst_n), .angle(angle_xz_reg), .cos_reg(cos_xz), .sin_reg(sin_xz)
    );

    // input register
    assign rdy0     = !v0_reg || r1_in;
    assign in_stall = !rdy0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (rdy0)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (rdy0 && in_valid)
        begin
            d0_reg.u     <= in_x;
            d0_reg.v     <= in_y;
            d0_reg.w     <= in_z;
            d0_reg.clamp <= 1'b0;
        end
    end

    // xy rotation: u = x, v = y, w = z
    epr_rotate u_rot_xy (
        .clk(clk), .rst_n(rst_n), .cos_val(cos_xy), .sin_val(sin_xy),
        .in_valid(v0_reg), .in_ready(r1_in), .in_data(d0_reg),
        .out_valid(v1), .out_ready(r1), .out_data(d1)
    );

    // yz rotation: u = y, v = z, w = x
    always_comb
    begin
        d2_in.u     = d1.v;
        d2_in.v     = d1.w;
        d2_in.w     = d1.u;
        d2_in.clamp = d1.clamp;
    end

    epr_rotate u_rot_yz (
        .clk(clk), .rst_n(rst_n), .cos_val(cos_yz), .sin_val(sin_yz),
        .in_valid(v1), .in_ready(r1), .in_data(d2_in),
        .out_valid(v2), .out_ready(r2), .out_data(d2)
    );

    // xz rotation: u = x, v = z, w = y
    always_comb
    begin
        d3_in.u     = d2.w;
        d3_in.v     = d2.v;
        d3_in.w     = d2.u;
        d3_in.clamp = d2.clamp;
    end

    epr_rotate u_rot_xz (
        .clk(clk), .rst_n(rst_n), .cos_val(cos_xz), .sin_val(sin_xz),
        .in_valid(v2), .in_ready(r2), .in_data(d3_in),
        .out_valid(v3), .out_ready(r2_in), .out_data(d3)
    );

    // result
    assign r2_in     = !out_stall;
    assign out_valid = v3;
    assign out_x     = d3.u;
    assign out_y     = d3.w;
    assign out_z     = d3.v;
    assign clamped   = d3.clamp;

endmodule

// File: sv/epr_checker.sv
// ----------------------------------------------------------------------------
// epr_sva
// Port-level checks of the euler point rotator, bound to the top level.
// ----------------------------------------------------------------------------
module epr_sva (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               cfg_valid,
    input logic                               cfg_ready,
    input logic                               in_stall,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic signed [epr_pkg::COORD_W-1:0] out_x,
    input logic signed [epr_pkg::COORD_W-1:0] out_y,
    input logic signed [epr_pkg::COORD_W-1:0] out_z,
    input logic                               clamped
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y)
            && $stable(out_z) && $stable(clamped))
        else $error("stalled result changed");

    // input stalls only when the whole pipeline is full and the output is held
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with room in the pipeline");

    // no backpressure on configuration
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

    // nothing comes out while in reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result shown during reset");

endmodule

bind euler_point_rotator epr_sva u_epr_sva (.*);
